### sv/rspe_pkg.sv
package rspe_pkg;

  // default number of parity lanes
  localparam int unsigned MAX_PARITY_DEF = 32;

  // reduction polynomial x^8+x^4+x^3+x^2+1
  localparam logic [8:0] GF_POLY = 9'h11D;

  // parity count after reset
  localparam logic [5:0] NP_RESET = 6'd10;

  // controller to datapath commands
  typedef struct packed {
    logic cfg_wr;     // load the parity count register
    logic init;       // clear remainder, seed generator and root
    logic gen_step;   // multiply generator by (x + root)
    logic absorb;     // divide one data byte into the remainder
    logic shift_out;  // move remainder one lane up, zero at the bottom
  } cmd_t;

  // multiply by x modulo the field polynomial
  function automatic logic [7:0] gf_xtime(input logic [7:0] x);
    gf_xtime = {x[6:0], 1'b0} ^ (x[7] ? GF_POLY[7:0] : 8'h00);
  endfunction

  // full field multiply, shift and add
  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    logic [7:0] x;
    acc = 8'h00;
    x   = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) begin
        acc = acc ^ x;
      end
      x = gf_xtime(x);
    end
    gf_mul = acc;
  endfunction

endpackage

### sv/rspe_if.sv
// data byte channel
interface rspe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// parity byte channel
interface rspe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] parity_byte;
  logic       last_parity;

  modport source (output valid, output parity_byte, output last_parity, input ready);
  modport sink   (input valid, input parity_byte, input last_parity, output ready);
endinterface

// parity count write channel
interface rspe_cfg_if;
  logic       valid;
  logic       ready;
  logic [5:0] num_parity;

  modport source (output valid, output num_parity, input ready);
  modport sink   (input valid, input num_parity, output ready);
endinterface

### sv/rspe_datapath.sv
module rspe_datapath #(
  parameter int unsigned MaxParity = rspe_pkg::MAX_PARITY_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  rspe_pkg::cmd_t          cmd_i,
  input  logic [5:0]              cfg_data_i,
  input  logic [7:0]              data_byte_i,
  output logic [(MaxParity > 1 ? $clog2(MaxParity) : 1)-1:0] n_top_o,
  output logic [7:0]              parity_byte_o
);

  localparam int unsigned IdxW = (MaxParity > 1) ? $clog2(MaxParity) : 1;

  logic [5:0]      num_q;
  logic [IdxW-1:0] n_top;
  logic [7:0]      gen_q [MaxParity];
  logic [7:0]      par_q [MaxParity];
  logic [7:0]      root_q;
  logic [7:0]      fb;
  logic [7:0]      mul_b;
  logic [7:0]      prod [MaxParity];

  // parity count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q <= rspe_pkg::NP_RESET;
    end else if (cmd_i.cfg_wr) begin
      num_q <= cfg_data_i;
    end
  end

  // saturate count to 1..MaxParity, as index of the top lane
  always_comb begin
    if (num_q == 6'd0) begin
      n_top = '0;
    end else if ({1'b0, num_q} > 7'(MaxParity)) begin
      n_top = IdxW'(MaxParity - 1);
    end else begin
      n_top = IdxW'(num_q - 6'd1);
    end
  end

  // feedback term and shared multiplier operand
  assign fb    = par_q[n_top] ^ data_byte_i;
  assign mul_b = cmd_i.gen_step ? root_q : fb;

  // one field multiplier per lane, shared by generator build and division
  for (genvar j = 0; j < MaxParity; j++) begin : g_lane
    assign prod[j] = rspe_pkg::gf_mul(gen_q[j], mul_b);
  end

  // generator coefficients and root
  always_ff @(posedge clk_i) begin
    if (cmd_i.init) begin
      gen_q[0] <= 8'h01;
      for (int j = 1; j < MaxParity; j++) begin
        gen_q[j] <= 8'h00;
      end
      root_q <= 8'h01;
    end else if (cmd_i.gen_step) begin
      gen_q[0] <= prod[0];
      for (int j = 1; j < MaxParity; j++) begin
        gen_q[j] <= prod[j] ^ gen_q[j-1];
      end
      root_q <= rspe_pkg::gf_xtime(root_q);
    end
  end

  // remainder lanes
  always_ff @(posedge clk_i) begin
    if (cmd_i.init) begin
      for (int j = 0; j < MaxParity; j++) begin
        par_q[j] <= 8'h00;
      end
    end else if (cmd_i.absorb) begin
      par_q[0] <= prod[0];
      for (int j = 1; j < MaxParity; j++) begin
        par_q[j] <= par_q[j-1] ^ prod[j];
      end
    end else if (cmd_i.shift_out) begin
      par_q[0] <= 8'h00;
      for (int j = 1; j < MaxParity; j++) begin
        par_q[j] <= par_q[j-1];
      end
    end
  end

  assign n_top_o       = n_top;
  assign parity_byte_o = par_q[n_top];

endmodule

### sv/rspe_ctrl.sv
module rspe_ctrl #(
  parameter int unsigned MaxParity = rspe_pkg::MAX_PARITY_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_valid_i,
  input  logic           in_valid_i,
  input  logic           in_last_i,
  input  logic           out_ready_i,
  input  logic [(MaxParity > 1 ? $clog2(MaxParity) : 1)-1:0] n_top_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  output logic           out_last_o,
  output rspe_pkg::cmd_t cmd_o
);

  localparam int unsigned IdxW = (MaxParity > 1) ? $clog2(MaxParity) : 1;

  localparam logic [1:0] S_INIT = 2'd0;
  localparam logic [1:0] S_GEN  = 2'd1;
  localparam logic [1:0] S_IDLE = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0]      state_q, state_d;
  logic [IdxW-1:0] cnt_q, cnt_d;
  logic            in_fire;

  // a count write takes the cycle, so no data byte is taken alongside it
  assign in_ready_o  = (state_q == S_IDLE) && !cfg_valid_i;
  assign out_valid_o = (state_q == S_EMIT);
  assign out_last_o  = (state_q == S_EMIT) && (cnt_q == '0);
  assign in_fire     = in_valid_i && in_ready_o;

  // sequencing of generator build, division and readout
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    if (cfg_valid_i) begin
      cmd_o.cfg_wr = 1'b1;
      state_d      = S_INIT;
    end else begin
      case (state_q)
        S_INIT: begin
          cmd_o.init = 1'b1;
          cnt_d      = n_top_i;
          state_d    = S_GEN;
        end
        S_GEN: begin
          cmd_o.gen_step = 1'b1;
          if (cnt_q == '0) begin
            state_d = S_IDLE;
          end else begin
            cnt_d = cnt_q - 1'b1;
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            cmd_o.absorb = 1'b1;
            if (in_last_i) begin
              cnt_d   = n_top_i;
              state_d = S_EMIT;
            end
          end
        end
        S_EMIT: begin
          if (out_ready_i) begin
            cmd_o.shift_out = 1'b1;
            if (cnt_q == '0) begin
              state_d = S_IDLE;
            end else begin
              cnt_d = cnt_q - 1'b1;
            end
          end
        end
        default: begin
          state_d = S_INIT;
        end
      endcase
    end
  end

  // state and lane counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

### sv/reed_solomon_parity_encoder.sv
// Systematic Reed-Solomon parity encoder over GF(256), field polynomial 0x11D, generator
// roots 2^0 .. 2^(n-1) with n the parity count (written value saturated to 1..MaxParity).
// While idle, and while no count write is offered, the block takes one data byte per cycle;
// every lane's field multiplier works in parallel on the feedback byte. A byte flagged last
// starts readout of the n parity bytes, highest lane first, one per accepted output
// transaction; input is held off until the last parity byte is taken. After reset and after
// every parity count write the generator is rebuilt on the same multiplier bank, a seed
// step followed by one step per root, with input held off; a write also abandons any
// partial message. The count port is always ready.
module reed_solomon_parity_encoder #(
  parameter int unsigned MaxParity = rspe_pkg::MAX_PARITY_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rspe_in_if.sink     data_i,
  rspe_out_if.source  parity_o,
  rspe_cfg_if.sink    cfg_i
);

  localparam int unsigned IdxW = (MaxParity > 1) ? $clog2(MaxParity) : 1;

  rspe_pkg::cmd_t  cmd;
  logic [IdxW-1:0] n_top;

  assign cfg_i.ready = 1'b1;

  // control sequencer
  rspe_ctrl #(
    .MaxParity (MaxParity)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_i.valid),
    .in_valid_i  (data_i.valid),
    .in_last_i   (data_i.last_byte),
    .out_ready_i (parity_o.ready),
    .n_top_i     (n_top),
    .in_ready_o  (data_i.ready),
    .out_valid_o (parity_o.valid),
    .out_last_o  (parity_o.last_parity),
    .cmd_o       (cmd)
  );

  // lfsr lanes and generator
  rspe_datapath #(
    .MaxParity (MaxParity)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .cfg_data_i    (cfg_i.num_parity),
    .data_byte_i   (data_i.data_byte),
    .n_top_o       (n_top),
    .parity_byte_o (parity_o.parity_byte)
  );

endmodule

### sv/rspe_checker.sv
module rspe_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       in_last_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_byte_i,
  input logic       out_last_i,
  input logic       cfg_valid_i
);

  // stalled parity transaction holds unless a count write aborts it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i && !cfg_valid_i
    |=> out_valid_i && $stable(out_byte_i) && $stable(out_last_i))
    else $error("stalled parity transaction changed");

  // input is held off during readout
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_i && out_valid_i))
    else $error("input ready during parity readout");

  // readout starts right after the last data byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_last_i && !cfg_valid_i |=> out_valid_i)
    else $error("no parity after last data byte");

  // readout ends with the flagged parity byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && out_last_i |=> !out_valid_i)
    else $error("parity continued past last byte");

endmodule

bind reed_solomon_parity_encoder rspe_checker u_rspe_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (data_i.valid),
  .in_ready_i  (data_i.ready),
  .in_last_i   (data_i.last_byte),
  .out_valid_i (parity_o.valid),
  .out_ready_i (parity_o.ready),
  .out_byte_i  (parity_o.parity_byte),
  .out_last_i  (parity_o.last_parity),
  .cfg_valid_i (cfg_i.valid)
);
